/* sv/alc_pkg.sv */
// ----------------------------------------------------------------------------
// alc_pkg
// types and constants shared by the associated legendre column unit
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int RR_W   = 20;            // numerator / denominator of a root ratio
  localparam int DIV_W  = RR_W + 64;     // quotient of num * 2^64 / den
  localparam int ROOT_W = DIV_W / 2;     // integer root of the quotient
  localparam int SQ_IN_W = 61;           // plain square root radicand

  localparam logic [63:0] INV_SQRT_4PI = 64'd1211587905;

  localparam logic [1:0] REG_ORDER_M      = 2'd0;
  localparam logic [1:0] REG_DEGREE_COUNT = 2'd1;
  localparam logic [1:0] REG_NORM_MODE    = 2'd2;

  typedef enum logic [1:0] {SH_RAW, SH_60, SH_32, SH_30} mul_shift_t;

  typedef struct packed {
    logic       start;
    logic       neg;
    mul_shift_t shift;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic sqrt_only;
  } root_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

  typedef enum logic [1:0] {RP_IDLE, RP_DIV, RP_SQRT} root_phase_t;

  typedef enum logic [4:0] {
    S_IDLE, S_XSQ, S_XSQ_W, S_SIN_W, S_PW, S_PW_W, S_F0, S_F0R_W, S_F0M_W,
    S_F, S_FR_W, S_FM_W, S_MAG, S_MAG_W, S_EMIT, S_P1, S_P1R_W, S_P1T_W,
    S_P1M_W, S_REC, S_RA_W, S_RB_W, S_S1_W, S_S2_W, S_RM_W
  } seq_state_t;

endpackage

/* sv/alc_if.sv */
// ----------------------------------------------------------------------------
// alc interfaces
// grid point, result and configuration channels
// ----------------------------------------------------------------------------
interface alc_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] grid_x;
  modport source (output valid, grid_x, input ready);
  modport sink (input valid, grid_x, output ready);
endinterface

interface alc_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] poly_value;
  logic [6:0]         degree_l;
  logic               is_last;
  modport source (output valid, poly_value, degree_l, is_last, input ready);
  modport sink (input valid, poly_value, degree_l, is_last, output ready);
endinterface

interface alc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/alc_mul.sv */
// ----------------------------------------------------------------------------
// alc_mul
// 64x64 magnitude multiplier from four 32x32 partial products, with
// round to nearest, right shift and clamp to 2^62 in the shifting modes, and sign
// ----------------------------------------------------------------------------
module alc_mul import alc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  input  logic [63:0]        a_in,
  input  logic [63:0]        b_in,
  output unit_rsp_t          rsp,
  output logic signed [63:0] res
);

  localparam logic [63:0] MAG_LIMIT = 64'd1 << 62;

  logic [63:0]  a;
  logic [63:0]  b;
  logic         neg;
  mul_shift_t   sh;
  logic [127:0] acc;
  logic [2:0]   step;
  logic         busy;
  logic         done;
  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [63:0]  part;
  logic [127:0] part_sh;
  logic [127:0] rnd_add;
  logic [127:0] rsum;
  logic [127:0] shifted;
  logic [63:0]  mag;

  always_comb begin
    case (step)
      3'd0: begin opa = a[31:0];  opb = b[31:0];  end
      3'd1: begin opa = a[31:0];  opb = b[63:32]; end
      3'd2: begin opa = a[63:32]; opb = b[31:0];  end
      default: begin opa = a[63:32]; opb = b[63:32]; end
    endcase
    part = 64'(opa) * 64'(opb);
    case (step)
      3'd0: part_sh = {64'd0, part};
      3'd1, 3'd2: part_sh = {32'd0, part, 32'd0};
      default: part_sh = {part, 64'd0};
    endcase
  end

  always_comb begin
    unique case (sh)
      SH_60: rnd_add = 128'd1 << 59;
      SH_32: rnd_add = 128'd1 << 31;
      SH_30: rnd_add = 128'd1 << 29;
      default: rnd_add = 128'd0;
    endcase
    rsum = acc + rnd_add;
    unique case (sh)
      SH_60: shifted = rsum >> 60;
      SH_32: shifted = rsum >> 32;
      SH_30: shifted = rsum >> 30;
      default: shifted = rsum;
    endcase
    if (sh == SH_RAW) begin
      mag = shifted[63:0];
    end else if ((|shifted[127:64]) || shifted[63:0] > MAG_LIMIT) begin
      mag = MAG_LIMIT;
    end else begin
      mag = shifted[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a   <= a_in;
      b   <= b_in;
      neg <= req.neg;
      sh  <= req.shift;
      acc <= '0;
    end else if (busy) begin
      if (step == 3'd4) begin
        res <= neg ? -$signed(mag) : $signed(mag);
      end else begin
        acc <= acc + part_sh;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;

endmodule

/* sv/alc_root.sv */
// ----------------------------------------------------------------------------
// alc_root
// bit-serial floor(sqrt(num * 2^64 / den)) by restoring division followed by
// a digit-by-digit square root; also a plain square root of a radicand
// ----------------------------------------------------------------------------
module alc_root import alc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  root_req_t           req,
  input  logic [RR_W-1:0]     num,
  input  logic [RR_W-1:0]     den,
  input  logic [SQ_IN_W-1:0]  rad,
  output unit_rsp_t           rsp,
  output logic [ROOT_W-1:0]   root
);

  localparam logic [6:0] DIV_LAST  = 7'(DIV_W - 1);
  localparam logic [6:0] SQRT_LAST = 7'(ROOT_W - 1);

  root_phase_t         phase;
  logic [6:0]          cnt;
  logic                done;
  logic [DIV_W-1:0]    work;
  logic [RR_W-1:0]     den_r;
  logic [RR_W-1:0]     rem_d;
  logic [ROOT_W+2:0]   rem_s;
  logic [ROOT_W-1:0]   rt;
  logic [RR_W:0]       rem2;
  logic                ge_d;
  logic [RR_W:0]       diff_d;
  logic [ROOT_W+2:0]   remv;
  logic [ROOT_W+2:0]   trial;
  logic                ge_s;

  always_comb begin
    rem2   = {rem_d, work[DIV_W-1]};
    ge_d   = rem2 >= {1'b0, den_r};
    diff_d = rem2 - {1'b0, den_r};
    remv   = {rem_s[ROOT_W:0], work[DIV_W-1:DIV_W-2]};
    trial  = {1'b0, rt, 2'b01};
    ge_s   = remv >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= RP_IDLE;
      cnt   <= 7'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        RP_IDLE: begin
          if (req.start) begin
            cnt <= 7'd0;
            if (req.sqrt_only) begin
              phase <= RP_SQRT;
            end else if (den == '0) begin
              done <= 1'b1;
            end else begin
              phase <= RP_DIV;
            end
          end
        end
        RP_DIV: begin
          if (cnt == DIV_LAST) begin
            phase <= RP_SQRT;
            cnt   <= 7'd0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        RP_SQRT: begin
          if (cnt == SQRT_LAST) begin
            phase <= RP_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        default: phase <= RP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      RP_IDLE: begin
        if (req.start) begin
          den_r <= den;
          rem_d <= '0;
          rem_s <= '0;
          rt    <= '0;
          if (req.sqrt_only) begin
            work <= {{(DIV_W-SQ_IN_W){1'b0}}, rad};
          end else begin
            work <= {num, 64'd0};
          end
        end
      end
      RP_DIV: begin
        rem_d <= ge_d ? diff_d[RR_W-1:0] : rem2[RR_W-1:0];
        work  <= {work[DIV_W-2:0], ge_d};
      end
      RP_SQRT: begin
        rem_s <= ge_s ? remv - trial : remv;
        rt    <= {rt[ROOT_W-2:0], ge_s};
        work  <= {work[DIV_W-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  assign rsp.busy = phase != RP_IDLE;
  assign rsp.done = done;
  assign root     = rt;

endmodule

/* sv/assoc_legendre_column_unit.sv */
// ----------------------------------------------------------------------------
// assoc_legendre_column_unit
// normalized associated legendre values P_l^m(x) for l = m .. m+count-1
// ----------------------------------------------------------------------------
// One grid point x (Q2.30) is taken while the unit is idle; it then emits
// count words, P_l^m in Q(48-FRAC_BITS).(FRAC_BITS) saturated to 48 bits,
// the last marked. All products and roots go through one 64x64 multiplier
// built from four 32x32 passes and one bit-serial divide-and-root unit. The
// first word needs the sine power and the scale factor (one more root and
// product in the orthonormal mode), the second a seed step and each further
// one a recurrence step, all dominated by the divide-and-root unit; the next
// point is taken once the last word is out of the sequencer. A finished word
// waits in the output register while work continues.
// ----------------------------------------------------------------------------
module assoc_legendre_column_unit import alc_pkg::*; #(
  parameter int MAX_COUNT = 64,
  parameter int MAX_ORDER = 63,
  parameter int FRAC_BITS = 42
) (
  input  logic   clk,
  input  logic   rst,
  alc_point_if.sink    point,
  alc_result_if.source result,
  alc_cfg_if.sink      cfg
);

  localparam int K = 60 - FRAC_BITS;
  localparam logic [63:0] K_HALF = 64'd1 << (K - 1);

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > $signed(64'h0000_7FFF_FFFF_FFFF)) begin
      sat48 = 48'sh7FFF_FFFF_FFFF;
    end else if (v < $signed(64'hFFFF_8000_0000_0000)) begin
      sat48 = 48'sh8000_0000_0000;
    end else begin
      sat48 = v[47:0];
    end
  endfunction

  logic [5:0] order_m;
  logic [6:0] degree_count;
  logic       norm_mode;

  seq_state_t state;
  seq_state_t state_next;

  logic signed [31:0] x;
  logic [5:0]         m;
  logic [6:0]         n;
  logic               norm;
  logic [6:0]         cnt;
  logic [6:0]         idx;
  logic [63:0]        s60;
  logic [63:0]        pw;
  logic [63:0]        f;
  logic signed [47:0] p1;
  logic signed [47:0] p2;
  logic signed [47:0] pend;
  logic [ROOT_W-1:0]  a_c;
  logic [ROOT_W-1:0]  b_c;
  logic signed [63:0] s1;

  logic               out_valid;
  logic signed [47:0] out_value;
  logic [6:0]         out_degree;
  logic               out_last;

  mul_req_t           mul_req;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  unit_rsp_t          mul_rsp;
  logic signed [63:0] mul_res;

  root_req_t          root_req;
  logic [RR_W-1:0]    root_num;
  logic [RR_W-1:0]    root_den;
  logic [SQ_IN_W-1:0] root_rad;
  unit_rsp_t          root_rsp;
  logic [ROOT_W-1:0]  root_val;

  logic signed [31:0] x_clamp;
  logic [5:0]         m_clamp;
  logic [6:0]         n_clamp;
  logic               emit_go;
  logic               emit_last;
  logic [63:0]        root_ext;
  logic signed [63:0] p0_val;
  logic [63:0]        p0_round;
  logic signed [63:0] s_diff;
  logic [8:0]         l;
  logic [8:0]         lm1;
  logic [9:0]         t1;
  logic [9:0]         t3;
  logic [RR_W-1:0]    sq_l;
  logic [RR_W-1:0]    sq_lm1;
  logic [RR_W-1:0]    sq_m;
  logic [RR_W-1:0]    num_a;
  logic [RR_W-1:0]    den_a;
  logic [RR_W-1:0]    num_b;
  logic [RR_W-1:0]    den_b;

  alc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .a_in (mul_a),
    .b_in (mul_b),
    .rsp  (mul_rsp),
    .res  (mul_res)
  );

  alc_root u_root (
    .clk  (clk),
    .rst  (rst),
    .req  (root_req),
    .num  (root_num),
    .den  (root_den),
    .rad  (root_rad),
    .rsp  (root_rsp),
    .root (root_val)
  );

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_m      <= 6'd0;
      degree_count <= 7'd1;
      norm_mode    <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ORDER_M:      order_m      <= cfg.data[5:0];
        REG_DEGREE_COUNT: degree_count <= cfg.data;
        REG_NORM_MODE:    norm_mode    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // input clamps and recurrence coefficients
  always_comb begin
    if (point.grid_x > 32'sd1073741824) begin
      x_clamp = 32'sd1073741824;
    end else if (point.grid_x < -32'sd1073741824) begin
      x_clamp = -32'sd1073741824;
    end else begin
      x_clamp = point.grid_x;
    end
    m_clamp = (32'(order_m) > MAX_ORDER) ? 6'(MAX_ORDER) : order_m;
    if (degree_count == 7'd0) begin
      n_clamp = 7'd1;
    end else if (32'(degree_count) > MAX_COUNT) begin
      n_clamp = 7'(MAX_COUNT);
    end else begin
      n_clamp = degree_count;
    end

    l      = 9'(m) + 9'(idx);
    lm1    = l - 9'd1;
    t1     = {l, 1'b0} - 10'd1;
    t3     = {l, 1'b0} - 10'd3;
    sq_l   = RR_W'(l) * RR_W'(l);
    sq_lm1 = RR_W'(lm1) * RR_W'(lm1);
    sq_m   = RR_W'(m) * RR_W'(m);
    num_a  = sq_lm1 - sq_m;
    den_b  = sq_l - sq_m;
    den_a  = norm ? RR_W'(t1) * RR_W'(t3) : RR_W'(t1) * RR_W'(t1);
    num_b  = norm ? {sq_l[RR_W-3:0], 2'b00} - RR_W'(1) : den_a;

    root_ext = 64'(root_val);
    p0_round = (64'(mul_res) + K_HALF) >> K;
    p0_val   = m[0] ? -$signed(p0_round) : $signed(p0_round);
    s_diff   = s1 - mul_res;
    emit_go  = !out_valid || result.ready;
    emit_last = idx == n - 7'd1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_req    = '0;
    mul_a      = '0;
    mul_b      = '0;
    root_req   = '0;
    root_num   = '0;
    root_den   = '0;
    root_rad   = '0;
    unique case (state)
      S_IDLE: begin
        if (point.valid) state_next = S_XSQ;
      end
      S_XSQ: begin
        mul_req.start = 1'b1;
        mul_req.shift = SH_RAW;
        mul_a = mag64(64'(x));
        mul_b = mag64(64'(x));
        state_next = S_XSQ_W;
      end
      S_XSQ_W: begin
        if (mul_rsp.done) begin
          root_req.start     = 1'b1;
          root_req.sqrt_only = 1'b1;
          root_rad = (SQ_IN_W'(1) << 60) - mul_res[SQ_IN_W-1:0];
          state_next = S_SIN_W;
        end
      end
      S_SIN_W: begin
        if (root_rsp.done) state_next = S_PW;
      end
      S_PW: begin
        if (cnt == 7'(m)) begin
          state_next = S_F0;
        end else begin
          mul_req.start = 1'b1;
          mul_req.shift = SH_60;
          mul_a = pw;
          mul_b = s60;
          state_next = S_PW_W;
        end
      end
      S_PW_W: begin
        if (mul_rsp.done) state_next = S_PW;
      end
      S_F0: begin
        if (norm) begin
          root_req.start = 1'b1;
          root_num = RR_W'({m, 1'b1});
          root_den = RR_W'(1);
          state_next = S_F0R_W;
        end else begin
          state_next = S_F;
        end
      end
      S_F0R_W: begin
        if (root_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.shift = SH_32;
          mul_a = root_ext;
          mul_b = INV_SQRT_4PI;
          state_next = S_F0M_W;
        end
      end
      S_F0M_W: begin
        if (mul_rsp.done) state_next = S_F;
      end
      S_F: begin
        if (cnt > 7'(m)) begin
          state_next = S_MAG;
        end else begin
          root_req.start = 1'b1;
          root_num = RR_W'({cnt, 1'b0}) - RR_W'(1);
          root_den = RR_W'({cnt, 1'b0});
          state_next = S_FR_W;
        end
      end
      S_FR_W: begin
        if (root_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.shift = SH_32;
          mul_a = f;
          mul_b = root_ext;
          state_next = S_FM_W;
        end
      end
      S_FM_W: begin
        if (mul_rsp.done) state_next = S_F;
      end
      S_MAG: begin
        mul_req.start = 1'b1;
        mul_req.shift = SH_32;
        mul_a = pw;
        mul_b = f;
        state_next = S_MAG_W;
      end
      S_MAG_W: begin
        if (mul_rsp.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          if (emit_last) begin
            state_next = S_IDLE;
          end else if (idx == 7'd0) begin
            state_next = S_P1;
          end else begin
            state_next = S_REC;
          end
        end
      end
      S_P1: begin
        root_req.start = 1'b1;
        root_num = norm ? RR_W'({m, 1'b1}) + RR_W'(2) : RR_W'({m, 1'b1});
        root_den = RR_W'(1);
        state_next = S_P1R_W;
      end
      S_P1R_W: begin
        if (root_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.shift = SH_32;
          mul_req.neg   = x[31];
          mul_a = mag64(64'(x));
          mul_b = root_ext;
          state_next = S_P1T_W;
        end
      end
      S_P1T_W: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.shift = SH_30;
          mul_req.neg   = mul_res[63] != p2[47];
          mul_a = mag64(mul_res);
          mul_b = mag64(64'(p2));
          state_next = S_P1M_W;
        end
      end
      S_P1M_W: begin
        if (mul_rsp.done) state_next = S_EMIT;
      end
      S_REC: begin
        root_req.start = 1'b1;
        root_num = num_a;
        root_den = den_a;
        state_next = S_RA_W;
      end
      S_RA_W: begin
        if (root_rsp.done) begin
          root_req.start = 1'b1;
          root_num = num_b;
          root_den = den_b;
          state_next = S_RB_W;
        end
      end
      S_RB_W: begin
        if (root_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.shift = SH_30;
          mul_req.neg   = x[31] != p1[47];
          mul_a = mag64(64'(x));
          mul_b = mag64(64'(p1));
          state_next = S_S1_W;
        end
      end
      S_S1_W: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.shift = SH_32;
          mul_req.neg   = p2[47];
          mul_a = 64'(a_c);
          mul_b = mag64(64'(p2));
          state_next = S_S2_W;
        end
      end
      S_S2_W: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.shift = SH_32;
          mul_req.neg   = s_diff[63];
          mul_a = mag64(s_diff);
          mul_b = 64'(b_c);
          state_next = S_RM_W;
        end
      end
      S_RM_W: begin
        if (mul_rsp.done) state_next = S_EMIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign point.ready = state == S_IDLE;

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (point.valid) begin
          x    <= x_clamp;
          m    <= m_clamp;
          n    <= n_clamp;
          norm <= norm_mode;
          idx  <= 7'd0;
        end
      end
      S_SIN_W: begin
        if (root_rsp.done) begin
          s60 <= root_ext << 30;
          pw  <= 64'd1 << 60;
          cnt <= 7'd0;
        end
      end
      S_PW_W: begin
        if (mul_rsp.done) begin
          pw  <= mul_res;
          cnt <= cnt + 7'd1;
        end
      end
      S_F0: begin
        if (!norm) begin
          f   <= 64'd1 << 32;
          cnt <= 7'd1;
        end
      end
      S_F0M_W: begin
        if (mul_rsp.done) begin
          f   <= mul_res;
          cnt <= 7'd1;
        end
      end
      S_FM_W: begin
        if (mul_rsp.done) begin
          f   <= mul_res;
          cnt <= cnt + 7'd1;
        end
      end
      S_MAG_W: begin
        if (mul_rsp.done) begin
          p2   <= sat48(p0_val);
          pend <= sat48(p0_val);
        end
      end
      S_EMIT: begin
        if (emit_go) idx <= idx + 7'd1;
      end
      S_P1M_W: begin
        if (mul_rsp.done) begin
          p1   <= sat48(mul_res);
          pend <= sat48(mul_res);
        end
      end
      S_RA_W: begin
        if (root_rsp.done) a_c <= root_val;
      end
      S_RB_W: begin
        if (root_rsp.done) b_c <= root_val;
      end
      S_S1_W: begin
        if (mul_rsp.done) s1 <= mul_res;
      end
      S_RM_W: begin
        if (mul_rsp.done) begin
          p2   <= p1;
          p1   <= sat48(mul_res);
          pend <= sat48(mul_res);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && emit_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_go) begin
      out_value  <= pend;
      out_degree <= 7'(7'(m) + idx);
      out_last   <= emit_last;
    end
  end

  assign result.valid      = out_valid;
  assign result.poly_value = out_value;
  assign result.degree_l   = out_degree;
  assign result.is_last    = out_last;

  // checks
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_root_idle: assert property (@(posedge clk) disable iff (rst)
    root_req.start |-> !root_rsp.busy)
    else $error("root unit started while busy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mul_rsp.busy && !root_rsp.busy))
    else $error("shared unit busy while sequencer idle");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_go && emit_last) |=> (state == S_IDLE))
    else $error("sequencer did not finish after last word");

endmodule
